@@ rtl/ll1_expression_recognizer_top_macros.svh @@
// assertion macros for the ll1 expression recognizer
// expects clock and reset signals in the module that uses them
`ifndef LL1_EXPRESSION_RECOGNIZER_TOP_MACROS_SVH
`define LL1_EXPRESSION_RECOGNIZER_TOP_MACROS_SVH

// plain property checked every clock
`define LL1ER_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define LL1ER_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LL1ER_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ll1er_pkg.sv @@
// shared types, codes and grammar tables of the ll1 expression recognizer
// no dependencies
package ll1er_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int MAX_RESULTS     = 40;
   localparam int CNT_W           = 6;

   typedef logic [4:0] sym_type;
   typedef logic [4:0] col_type;
   typedef logic [4:0] prod_type;

   localparam sym_type SYM_E     = 5'd0;
   localparam sym_type SYM_EP    = 5'd1;
   localparam sym_type SYM_TP    = 5'd3;
   localparam sym_type SYM_NP    = 5'd6;
   localparam sym_type SYM_TERM0 = 5'd8;

   localparam col_type COL_LPAR  = 5'd10;
   localparam col_type COL_RPAR  = 5'd11;
   localparam col_type COL_PLUS  = 5'd12;
   localparam col_type COL_MINUS = 5'd13;
   localparam col_type COL_STAR  = 5'd14;
   localparam col_type COL_SLASH = 5'd15;
   localparam col_type COL_NONE  = 5'd16;

   localparam prod_type PROD_NONE    = 5'd0;
   localparam prod_type PROD_T_EMPTY = 5'd4;
   localparam prod_type PROD_F_EMPTY = 5'd8;
   localparam prod_type PROD_N_EMPTY = 5'd13;

   typedef enum logic [2:0] {
      KIND_PROD     = 3'd0,
      KIND_CONSUME  = 3'd1,
      KIND_ACCEPT   = 3'd2,
      KIND_ERROR    = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_RELOAD,
      CMD_POP,
      CMD_EXPAND,
      CMD_PUSH2,
      CMD_FILL
   } stack_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PUSH2,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      prod_type   production;
      logic       last;
   } rsp_type;

   typedef struct packed {
      stack_cmd_type cmd;
      prod_type      prod;
   } stack_ctl_type;

   typedef struct packed {
      kind_type      kind;
      prod_type      prod;
      logic          last;
      stack_cmd_type cmd;
   } step_type;

   localparam int PRED_TABLE [8][16] = '{
      '{ 1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  1,  0,  0,  0,  0,  0},
      '{ 4,  4,  4,  4,  4,  4,  4,  4,  4,  4,  4,  4,  2,  3,  4,  4},
      '{ 5,  5,  5,  5,  5,  5,  5,  5,  5,  5,  5,  0,  0,  0,  0,  0},
      '{ 8,  8,  8,  8,  8,  8,  8,  8,  8,  8,  8,  8,  8,  8,  6,  7},
      '{ 9,  9,  9,  9,  9,  9,  9,  9,  9,  9, 10,  0,  0,  0,  0,  0},
      '{11, 11, 11, 11, 11, 11, 11, 11, 11, 11,  0,  0,  0,  0,  0,  0},
      '{12, 12, 12, 12, 12, 12, 12, 12, 12, 12, 13, 13, 13, 13, 13, 13},
      '{14, 15, 16, 17, 18, 19, 20, 21, 22, 23,  0,  0,  0,  0,  0,  0}
   };

   // right-hand sides, leftmost symbol first
   localparam int RHS_LEN [24] = '{
      0, 2, 3, 3, 0, 2, 3, 3, 0, 1, 3, 2, 1, 0,
      1, 1, 1, 1, 1, 1, 1, 1, 1, 1
   };

   localparam int RHS_SYM [24][3] = '{
      '{ 0, 0, 0}, '{ 2, 1, 0}, '{20, 2, 1}, '{21, 2, 1},
      '{ 0, 0, 0}, '{ 4, 3, 0}, '{22, 4, 3}, '{23, 4, 3},
      '{ 0, 0, 0}, '{ 5, 0, 0}, '{18, 0, 19}, '{ 7, 6, 0},
      '{ 5, 0, 0}, '{ 0, 0, 0},
      '{ 8, 0, 0}, '{ 9, 0, 0}, '{10, 0, 0}, '{11, 0, 0}, '{12, 0, 0},
      '{13, 0, 0}, '{14, 0, 0}, '{15, 0, 0}, '{16, 0, 0}, '{17, 0, 0}
   };

   function automatic col_type column_of(input logic [7:0] ch);
      col_type col;
      col = COL_NONE;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         col = 5'(ch - 8'h30);
      end else begin
         case (ch)
            8'h28:   col = COL_LPAR;
            8'h29:   col = COL_RPAR;
            8'h2B:   col = COL_PLUS;
            8'h2D:   col = COL_MINUS;
            8'h2A:   col = COL_STAR;
            8'h2F:   col = COL_SLASH;
            default: col = COL_NONE;
         endcase
      end
      return col;
   endfunction

   function automatic prod_type pred_prod(input logic [2:0] row, input logic [3:0] col);
      return 5'(PRED_TABLE[row][col]);
   endfunction

   function automatic logic [1:0] rhs_len(input prod_type prod);
      logic [1:0] len;
      len = 2'd0;
      if (prod < 5'd24) begin
         len = 2'(RHS_LEN[prod]);
      end
      return len;
   endfunction

   function automatic sym_type rhs_sym(input prod_type prod, input logic [1:0] idx);
      sym_type sym;
      sym = SYM_E;
      if (prod < 5'd24 && idx < 2'd3) begin
         sym = 5'(RHS_SYM[prod][idx]);
      end
      return sym;
   endfunction

endpackage

@@ rtl/ll1er_step.sv @@
// one parser step: table lookup and decision for the symbol on top of the stack
// depends on ll1er_pkg
module ll1er_step
   import ll1er_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int SP_W = $clog2(STACK_DEPTH + 1)
) (
   input  sym_type           top,
   input  logic [SP_W-1:0]   sp,
   input  col_type           col,
   input  logic              at_end,
   input  logic [CNT_W-1:0]  count,
   output step_type          step
);

   prod_type        prod;
   logic [1:0]      len;
   logic [SP_W:0]   reach;

   always_comb begin
      prod = PROD_NONE;
      if (at_end) begin
         case (top)
            SYM_EP:  prod = PROD_T_EMPTY;
            SYM_TP:  prod = PROD_F_EMPTY;
            SYM_NP:  prod = PROD_N_EMPTY;
            default: prod = PROD_NONE;
         endcase
      end else if (col != COL_NONE && top < SYM_TERM0) begin
         prod = pred_prod(top[2:0], col[3:0]);
      end
   end

   assign len   = rhs_len(prod);
   assign reach = {1'b0, sp} + (SP_W + 1)'(len);

   always_comb begin
      step.kind = KIND_ERROR;
      step.prod = PROD_NONE;
      step.last = 1'b1;
      step.cmd  = CMD_RELOAD;
      if (count >= CNT_W'(MAX_RESULTS - 1)) begin
         step.kind = KIND_ERROR;
      end else if (!at_end && col == COL_NONE) begin
         step.kind = KIND_ERROR;
      end else if (sp == '0) begin
         step.kind = at_end ? KIND_ACCEPT : KIND_ERROR;
      end else if (top >= SYM_TERM0) begin
         if (!at_end && (top - SYM_TERM0) == col) begin
            step.kind = KIND_CONSUME;
            step.cmd  = CMD_POP;
         end
      end else if (prod == PROD_NONE) begin
         step.kind = KIND_ERROR;
      end else if (reach > (SP_W + 1)'(STACK_DEPTH + 1)) begin
         step.kind = KIND_OVERFLOW;
      end else begin
         step.kind = KIND_PROD;
         step.prod = prod;
         step.last = 1'b0;
         step.cmd  = (len == 2'd0) ? CMD_POP : CMD_EXPAND;
      end
   end

endmodule

@@ rtl/ll1er_stack.sv @@
// symbol stack: top register, pointer adder and memory with one write and one read port below the top
// depends on ll1er_pkg and the assertion macro header
`include "ll1_expression_recognizer_top_macros.svh"

module ll1er_stack
   import ll1er_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int SP_W = $clog2(STACK_DEPTH + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  stack_ctl_type   ctl,
   output logic [SP_W-1:0] sp,
   output sym_type         top
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   sym_type              mem [STACK_DEPTH];
   logic [SP_W-1:0]      sp_ff, sp_in;
   sym_type              top_ff, top_in;
   sym_type              rd_data_ff;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic                 wr_en;
   sym_type              wr_data;
   logic [1:0]           len;
   logic [SP_W-1:0]      base;

   assign len     = rhs_len(ctl.prod);
   assign base    = sp_ff - SP_W'(1);
   assign rd_addr = ADDR_W'(sp_ff - SP_W'(2));

   always_comb begin
      sp_in   = sp_ff;
      top_in  = top_ff;
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(base);
      wr_data = rhs_sym(ctl.prod, 2'(len - 2'd1));
      unique case (ctl.cmd)
         CMD_NONE: begin
         end
         CMD_RELOAD: begin
            sp_in  = SP_W'(1);
            top_in = SYM_E;
         end
         CMD_POP: begin
            sp_in = base;
         end
         CMD_EXPAND: begin
            sp_in  = base + SP_W'(len);
            top_in = rhs_sym(ctl.prod, 2'd0);
            wr_en  = (len >= 2'd2);
         end
         CMD_PUSH2: begin
            wr_en   = 1'b1;
            wr_addr = rd_addr;
            wr_data = rhs_sym(ctl.prod, 2'd1);
         end
         CMD_FILL: begin
            top_in = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= SP_W'(1);
         top_ff <= SYM_E;
      end else begin
         sp_ff  <= sp_in;
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign sp  = sp_ff;
   assign top = top_ff;

   `LL1ER_ASSERT(a_sp_in_range, sp_ff <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
   `LL1ER_ASSERT_NXT(a_reload, ctl.cmd == CMD_RELOAD, sp_ff == SP_W'(1) && top_ff == SYM_E, "reload did not restore start symbol")
   `LL1ER_ASSERT_NXT(a_expand_nonempty, ctl.cmd == CMD_EXPAND, sp_ff != '0, "expansion left stack empty")

endmodule

@@ rtl/ll1_expression_recognizer_top.sv @@
// ll1 expression recognizer top: sequencer, step unit, symbol stack, output register
// one result per cycle in the eval state while the output register is free
// a 3-symbol push passes through the push2 state, a pop that leaves symbols on the stack through the fill state
// a result held by rsp_stall stalls the eval state; requests are stalled meanwhile
// results leave through a registered output; the next item is taken while the last result waits
// synchronous active-high reset: stack holds E alone, pointer 1, no clearing pass
`include "ll1_expression_recognizer_top_macros.svh"

module ll1_expression_recognizer_top
   import ll1er_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   col_type            col_ff;
   logic               at_end_ff;
   logic [CNT_W-1:0]   count_ff;
   prod_type           prod_ff;
   logic               done_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_payload_ff;

   logic               req_xfer;
   logic               out_free;
   logic               rsp_load;
   step_type           step;
   stack_ctl_type      stack_ctl;
   logic [SP_W-1:0]    sp;
   sym_type            top;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   ll1er_step #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_step (
      .top   (top),
      .sp    (sp),
      .col   (col_ff),
      .at_end(at_end_ff),
      .count (count_ff),
      .step  (step)
   );

   ll1er_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock(clock),
      .reset(reset),
      .ctl  (stack_ctl),
      .sp   (sp),
      .top  (top)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               if (step.cmd == CMD_EXPAND && rhs_len(step.prod) == 2'd3) begin
                  state_in = ST_PUSH2;
               end else if (step.cmd == CMD_POP && sp > SP_W'(1)) begin
                  state_in = ST_FILL;
               end else if (step.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PUSH2: begin
            state_in = ST_EVAL;
         end
         ST_FILL: begin
            state_in = done_ff ? ST_IDLE : ST_EVAL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      rsp_load       = 1'b0;
      stack_ctl.cmd  = CMD_NONE;
      stack_ctl.prod = prod_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EVAL: begin
            stack_ctl.prod = step.prod;
            if (out_free) begin
               rsp_load      = 1'b1;
               stack_ctl.cmd = step.cmd;
            end
         end
         ST_PUSH2: begin
            stack_ctl.cmd = CMD_PUSH2;
         end
         ST_FILL: begin
            stack_ctl.cmd = CMD_FILL;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         col_ff    <= column_of(req_payload.char_code);
         at_end_ff <= req_payload.is_end;
         count_ff  <= '0;
         done_ff   <= 1'b0;
      end else if (rsp_load) begin
         count_ff  <= count_ff + CNT_W'(1);
         done_ff   <= step.last;
      end
      if (rsp_load) begin
         prod_ff                   <= step.prod;
         rsp_payload_ff.kind       <= step.kind;
         rsp_payload_ff.production <= step.prod;
         rsp_payload_ff.last       <= step.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `LL1ER_ASSERT_IMP(a_final_kind_last, rsp_valid && rsp_payload.kind != KIND_PROD,
      rsp_payload.last, "final result kind without last")
   `LL1ER_ASSERT_IMP(a_prod_not_last, rsp_valid && rsp_payload.kind == KIND_PROD,
      !rsp_payload.last && rsp_payload.production != PROD_NONE, "bad production transfer")
   `LL1ER_ASSERT_IMP(a_fill_after_pop, state_ff == ST_FILL,
      $past(stack_ctl.cmd == CMD_POP), "refill without pop")

endmodule

@@ dv/tb_ll1_expression_recognizer_top.sv @@
// self-checking testbench for ll1_expression_recognizer_top: directed and random expression
// streams under varying idle and stall, with a parse predictor and a result queue
// depends on ll1er_pkg and rtl/ll1_expression_recognizer_top.sv
module tb_ll1_expression_recognizer_top
   import ll1er_pkg::*;
();

   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 10;

   // grammar symbols not named in the package
   localparam sym_type SY_TERM   = 5'd2;
   localparam sym_type SY_FACTOR = 5'd4;
   localparam sym_type SY_NUMBER = 5'd5;
   localparam sym_type SY_DIGIT  = 5'd7;
   localparam sym_type SY_LPAR   = SYM_TERM0 + COL_LPAR;
   localparam sym_type SY_RPAR   = SYM_TERM0 + COL_RPAR;
   localparam sym_type SY_PLUS   = SYM_TERM0 + COL_PLUS;
   localparam sym_type SY_MINUS  = SYM_TERM0 + COL_MINUS;
   localparam sym_type SY_STAR   = SYM_TERM0 + COL_STAR;
   localparam sym_type SY_SLASH  = SYM_TERM0 + COL_SLASH;

   localparam prod_type P_EXPR         = 5'd1;
   localparam prod_type P_ADD          = 5'd2;
   localparam prod_type P_SUB          = 5'd3;
   localparam prod_type P_TERM         = 5'd5;
   localparam prod_type P_MUL          = 5'd6;
   localparam prod_type P_DIV          = 5'd7;
   localparam prod_type P_FACTOR_NUM   = 5'd9;
   localparam prod_type P_FACTOR_PAREN = 5'd10;
   localparam prod_type P_NUMBER       = 5'd11;
   localparam prod_type P_NUMBER_MORE  = 5'd12;
   localparam prod_type P_DIGIT0       = 5'd14;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int items_sent     = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;

   rsp_type    expected_events[$];
   rsp_type    held_event;
   bit         held_valid = 1'b0;
   sym_type    symbol_stack[STACK_DEPTH_DEF];
   int         stack_used;
   logic [7:0] expr_text[$];

   ll1_expression_recognizer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic void reload_stack();
      foreach (symbol_stack[i]) symbol_stack[i] = SYM_E;
      stack_used = 1;
   endfunction

   function automatic col_type char_column(input logic [7:0] ch);
      col_type col;
      col = COL_NONE;
      if (ch >= "0" && ch <= "9") begin
         col = col_type'(ch - "0");
      end else begin
         case (ch)
            "(":     col = COL_LPAR;
            ")":     col = COL_RPAR;
            "+":     col = COL_PLUS;
            "-":     col = COL_MINUS;
            "*":     col = COL_STAR;
            "/":     col = COL_SLASH;
            default: col = COL_NONE;
         endcase
      end
      return col;
   endfunction

   function automatic prod_type table_prod(input sym_type top, input col_type col);
      prod_type p;
      logic     is_digit;
      logic     opens_operand;
      p = PROD_NONE;
      is_digit = (col < COL_LPAR);
      opens_operand = (col <= COL_LPAR);
      case (top)
         SYM_E: begin
            if (opens_operand) p = P_EXPR;
         end
         SYM_EP: begin
            if (col == COL_PLUS) p = P_ADD;
            else if (col == COL_MINUS) p = P_SUB;
            else p = PROD_T_EMPTY;
         end
         SY_TERM: begin
            if (opens_operand) p = P_TERM;
         end
         SYM_TP: begin
            if (col == COL_STAR) p = P_MUL;
            else if (col == COL_SLASH) p = P_DIV;
            else p = PROD_F_EMPTY;
         end
         SY_FACTOR: begin
            if (is_digit) p = P_FACTOR_NUM;
            else if (col == COL_LPAR) p = P_FACTOR_PAREN;
         end
         SY_NUMBER: begin
            if (is_digit) p = P_NUMBER;
         end
         SYM_NP: begin
            p = is_digit ? P_NUMBER_MORE : PROD_N_EMPTY;
         end
         SY_DIGIT: begin
            if (is_digit) p = prod_type'(P_DIGIT0 + col);
         end
         default: p = PROD_NONE;
      endcase
      return p;
   endfunction

   // replaces the nonterminal on top by the right-hand side, leftmost symbol on top
   function automatic bit push_rhs(input prod_type p);
      sym_type rhs[3];
      int      len;
      int      base_idx;
      int      k;
      rhs = '{default: SYM_E};
      len = 0;
      case (p)
         P_EXPR:         begin rhs = '{SY_TERM, SYM_EP, SYM_E};       len = 2; end
         P_ADD:          begin rhs = '{SY_PLUS, SY_TERM, SYM_EP};     len = 3; end
         P_SUB:          begin rhs = '{SY_MINUS, SY_TERM, SYM_EP};    len = 3; end
         P_TERM:         begin rhs = '{SY_FACTOR, SYM_TP, SYM_E};     len = 2; end
         P_MUL:          begin rhs = '{SY_STAR, SY_FACTOR, SYM_TP};   len = 3; end
         P_DIV:          begin rhs = '{SY_SLASH, SY_FACTOR, SYM_TP};  len = 3; end
         P_FACTOR_NUM:   begin rhs = '{SY_NUMBER, SYM_E, SYM_E};      len = 1; end
         P_FACTOR_PAREN: begin rhs = '{SY_LPAR, SYM_E, SY_RPAR};      len = 3; end
         P_NUMBER:       begin rhs = '{SY_DIGIT, SYM_NP, SYM_E};      len = 2; end
         P_NUMBER_MORE:  begin rhs = '{SY_NUMBER, SYM_E, SYM_E};      len = 1; end
         default: begin
            if (p >= P_DIGIT0) begin
               rhs[0] = sym_type'(SYM_TERM0 + (p - P_DIGIT0));
               len = 1;
            end
         end
      endcase
      base_idx = stack_used - 1;
      if (base_idx + len > STACK_DEPTH_DEF) return 1'b0;
      for (k = 0; k < len; k++) symbol_stack[base_idx + k] = rhs[len - 1 - k];
      stack_used = base_idx + len;
      return 1'b1;
   endfunction

   function automatic void emit_event(input kind_type kind, input prod_type production);
      if (held_valid) expected_events.push_back(held_event);
      held_event.kind = kind;
      held_event.production = production;
      held_event.last = 1'b0;
      held_valid = 1'b1;
   endfunction

   function automatic void derive_parse_events(input req_type item);
      col_type  col;
      sym_type  top;
      prod_type p;
      int       produced;
      bit       done;
      col = char_column(item.char_code);
      produced = 0;
      done = 1'b0;
      if (!item.is_end && col == COL_NONE) begin
         emit_event(KIND_ERROR, PROD_NONE);
         reload_stack();
      end else begin
         while (!done) begin
            if (produced >= MAX_RESULTS - 1) begin
               emit_event(KIND_ERROR, PROD_NONE);
               reload_stack();
               done = 1'b1;
            end else if (stack_used == 0) begin
               if (item.is_end) emit_event(KIND_ACCEPT, PROD_NONE);
               else emit_event(KIND_ERROR, PROD_NONE);
               reload_stack();
               done = 1'b1;
            end else begin
               top = symbol_stack[stack_used - 1];
               if (top >= SYM_TERM0) begin
                  if (!item.is_end && (top - SYM_TERM0) == col) begin
                     stack_used--;
                     symbol_stack[stack_used] = SYM_E;
                     emit_event(KIND_CONSUME, PROD_NONE);
                  end else begin
                     emit_event(KIND_ERROR, PROD_NONE);
                     reload_stack();
                  end
                  done = 1'b1;
               end else begin
                  if (item.is_end) begin
                     case (top)
                        SYM_EP:  p = PROD_T_EMPTY;
                        SYM_TP:  p = PROD_F_EMPTY;
                        SYM_NP:  p = PROD_N_EMPTY;
                        default: p = PROD_NONE;
                     endcase
                  end else begin
                     p = table_prod(top, col);
                  end
                  if (p == PROD_NONE) begin
                     emit_event(KIND_ERROR, PROD_NONE);
                     reload_stack();
                     done = 1'b1;
                  end else if (!push_rhs(p)) begin
                     emit_event(KIND_OVERFLOW, PROD_NONE);
                     reload_stack();
                     done = 1'b1;
                  end else begin
                     emit_event(KIND_PROD, p);
                  end
               end
            end
            produced++;
         end
      end
      held_event.last = 1'b1;
      expected_events.push_back(held_event);
      held_valid = 1'b0;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            note_mismatch($sformatf("unexpected result transfer: kind %0d prod %0d last %0b",
                                    rsp_payload.kind, rsp_payload.production, rsp_payload.last));
         end else begin
            want = expected_events.pop_front();
            if (rsp_payload.kind !== want.kind || rsp_payload.production !== want.production ||
                rsp_payload.last !== want.last) begin
               note_mismatch($sformatf(
                  "result transfer differs: kind %0d/%0d prod %0d/%0d last %0b/%0b (exp/act)",
                  want.kind, rsp_payload.kind, want.production, rsp_payload.production,
                  want.last, rsp_payload.last));
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver: long hold-off when requested, random stall otherwise
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_symbol(input logic [7:0] ch, input logic end_flag);
      req_type item;
      item.char_code = ch;
      item.is_end = end_flag;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      derive_parse_events(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input bit with_end);
      foreach (expr_text[i]) send_symbol(expr_text[i], 1'b0);
      if (with_end) send_symbol(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_string(input string s, input bit with_end);
      expr_text.delete();
      for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
      send_text(with_end);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_operator();
      logic [7:0] op;
      case ($urandom_range(3))
         0:       op = "+";
         1:       op = "-";
         2:       op = "*";
         default: op = "/";
      endcase
      return op;
   endfunction

   // well-formed expression with random numbers, operators and nesting
   function automatic void build_expression(input int operands, input int max_nest);
      int open_cnt;
      int k;
      expr_text.delete();
      open_cnt = 0;
      for (k = 0; k < operands; k++) begin
         if (k > 0) expr_text.push_back(random_operator());
         while (open_cnt < max_nest && $urandom_range(3) == 0) begin
            expr_text.push_back("(");
            open_cnt++;
         end
         repeat ($urandom_range(1, 3)) expr_text.push_back(8'("0" + $urandom_range(9)));
         while (open_cnt > 0 && $urandom_range(1) == 0) begin
            expr_text.push_back(")");
            open_cnt--;
         end
      end
      while (open_cnt > 0) begin
         expr_text.push_back(")");
         open_cnt--;
      end
   endfunction

   task automatic send_random_sequence();
      int pick;
      int pos;
      pick = $urandom_range(99);
      build_expression($urandom_range(1, 6), 3);
      if (pick < 70) begin
         send_text(1'b1);
      end else if (pick < 80) begin
         // corrupt one character
         pos = $urandom_range(expr_text.size() - 1);
         case ($urandom_range(2))
            0:       expr_text[pos] = 8'($urandom_range(255));
            1:       expr_text[pos] = random_operator();
            default: expr_text[pos] = $urandom_range(1) ? 8'("(") : 8'(")");
         endcase
         send_text(1'b1);
      end else if (pick < 85) begin
         pos = $urandom_range(expr_text.size() - 1);
         expr_text.delete(pos);
         send_text(1'b1);
      end else if (pick < 90) begin
         send_text(1'b0);
      end else if (pick < 93) begin
         // deep nesting, overflows past ten open parentheses
         expr_text.delete();
         repeat ($urandom_range(8, 14)) expr_text.push_back("(");
         expr_text.push_back("7");
         send_text(1'b1);
      end else begin
         repeat ($urandom_range(1, 3)) begin
            send_symbol(8'($urandom_range(255)), ($urandom_range(3) == 0));
         end
      end
   endtask

   task automatic test_well_formed_expression();
      send_string("(0+9)*1-2/3", 1'b1);
   endtask

   task automatic test_syntax_errors();
      send_string("a", 1'b0);          // unknown character
      send_symbol(8'hFF, 1'b1);        // end marker with start symbol on top
      send_string(")", 1'b0);          // empty table entry
      send_string("(2(", 1'b0);        // terminal mismatch
      send_string("5(", 1'b0);         // character after a complete expression
   endtask

   task automatic test_stack_overflow();
      send_string("(((((((((((", 1'b0);
   endtask

   task automatic test_long_receiver_hold();
      hold_request = HOLD_CYCLES;
      build_expression(8, 2);
      send_text(1'b1);
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      int target;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = items_sent + count;
      while (items_sent < target) send_random_sequence();
   endtask

   initial begin
      reload_stack();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_well_formed_expression();
      test_syntax_errors();
      test_stack_overflow();
      test_long_receiver_hold();
      test_random_traffic(0, 0, 110);
      test_random_traffic(76, 0, 110);
      test_random_traffic(0, 76, 110);
      test_random_traffic(8, 8, 110);
      wait_for_drain();
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
